[rtl/core/iad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed array package
// Widths, operation codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package iad_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DATA_W          = 32;
  localparam int COUNT_W         = 5;
  localparam int POS_W           = 5;
  localparam int ACT_W           = 2;
  localparam int STAT_W          = 2;

  localparam logic [COUNT_W-1:0] CAP_RESET = 5'd10;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_PREV,
    RD_HERE,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_BAD_INDEX,
    FIN_FULL,
    FIN_INSERT,
    FIN_DELETE,
    FIN_HIT,
    FIN_MISS
  } fin_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_shift;
    idx_op_t idx_op;
    logic    take_removed;
    fin_t    fin;
  } dp_cmd_t;

  typedef struct packed {
    action_t act;
    logic    ins_bad;
    logic    full;
    logic    del_bad;
    logic    ins_more;
    logic    del_more;
    logic    srch_more;
    logic    hit;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/iad_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/iad_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed array datapath
// Item registers, walking index, entry store, count, running sum and the
// result registers.
// ----------------------------------------------------------------------------
module iad_dpath #(
  parameter int MAX_ENTRIES = iad_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [iad_pkg::COUNT_W-1:0]       capacity,
  input  wire iad_pkg::action_t                  action,
  input  wire logic [iad_pkg::POS_W-1:0]         position,
  input  wire logic signed [iad_pkg::DATA_W-1:0] item_value,
  input  wire iad_pkg::dp_cmd_t                  cmd,
  output iad_pkg::dp_stat_t                      stat,
  output logic                                   done,
  output logic [iad_pkg::STAT_W-1:0]             status,
  output logic signed [iad_pkg::DATA_W-1:0]      removed_value,
  output logic                                   found,
  output logic signed [iad_pkg::DATA_W-1:0]      total,
  output logic [iad_pkg::COUNT_W-1:0]            count
);
  import iad_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  action_t            act_q;
  logic [POS_W-1:0]   pos_q;
  logic [DATA_W-1:0]  val_q;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] idx_next;
  logic [COUNT_W-1:0] rd_idx;
  logic [COUNT_W-1:0] wr_idx;
  logic [DATA_W-1:0]  rd_data;
  logic [DATA_W-1:0]  wr_data;
  logic [DATA_W-1:0]  sum;
  status_t            status_q;
  logic               full;

  // Effective capacity is the smaller of the register and the store depth
  always_comb begin
    if (32'(capacity) < MAX_ENTRIES) begin
      full = (count >= capacity);
    end else begin
      full = (32'(count) >= MAX_ENTRIES);
    end
  end

  always_comb begin
    stat.act       = act_q;
    stat.ins_bad   = (pos_q > count);
    stat.full      = full;
    stat.del_bad   = (pos_q >= count);
    stat.ins_more  = (idx > pos_q);
    stat.del_more  = (({1'b0, idx} + 6'd1) < {1'b0, count});
    stat.srch_more = (idx < count);
    stat.hit       = (rd_data == val_q);
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_idx = idx - 5'd1;
      RD_NEXT: rd_idx = idx + 5'd1;
      default: rd_idx = idx;
    endcase
  end

  assign wr_idx  = cmd.wr_shift ? idx : pos_q;
  assign wr_data = cmd.wr_shift ? rd_data : val_q;

  iad_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (AW'(wr_idx)),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (AW'(rd_idx)),
    .rd_data (rd_data)
  );

  always_comb begin
    case (cmd.idx_op)
      IDX_COUNT: idx_next = count;
      IDX_POS:   idx_next = pos_q;
      IDX_ZERO:  idx_next = '0;
      IDX_INC:   idx_next = idx + 5'd1;
      IDX_DEC:   idx_next = idx - 5'd1;
      default:   idx_next = idx;
    endcase
  end

  // Control state: count, sum and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (cmd.fin != FIN_NONE);
      case (cmd.fin)
        FIN_INSERT: begin
          count <= count + 5'd1;
          sum   <= sum + val_q;
        end
        FIN_DELETE: begin
          count <= count - 5'd1;
          sum   <= sum - removed_value;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action;
      pos_q <= position;
      val_q <= item_value;
    end
    idx <= idx_next;
    if (cmd.take_removed) begin
      removed_value <= rd_data;
    end
    case (cmd.fin)
      FIN_BAD_INDEX: begin
        status_q      <= ST_BAD_INDEX;
        removed_value <= '1;
        found         <= 1'b0;
      end
      FIN_FULL: begin
        status_q      <= ST_FULL;
        removed_value <= '0;
        found         <= 1'b0;
      end
      FIN_INSERT: begin
        status_q      <= ST_DONE;
        removed_value <= '0;
        found         <= 1'b0;
      end
      FIN_DELETE: begin
        // keep the word taken from the store
        status_q <= ST_DONE;
        found    <= 1'b0;
      end
      FIN_HIT: begin
        status_q      <= ST_DONE;
        removed_value <= '0;
        found         <= 1'b1;
      end
      FIN_MISS: begin
        status_q      <= ST_DONE;
        removed_value <= '0;
        found         <= 1'b0;
      end
      default: ;
    endcase
  end

  assign status = status_q;
  assign total  = sum;

endmodule
`default_nettype wire

[rtl/core/iad_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed array controller
// Sequences the checks, the shift walks and the search scan of one item.
// ----------------------------------------------------------------------------
module iad_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire iad_pkg::dp_stat_t stat,
  output iad_pkg::dp_cmd_t       cmd,
  output logic                   busy
);
  import iad_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_TEST,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_TAKE,
    S_DEL_TEST,
    S_DEL_WR,
    S_SRCH_TEST,
    S_SRCH_CMP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next       = state;
    cmd.load         = 1'b0;
    cmd.rd_en        = 1'b0;
    cmd.rd_sel       = RD_HERE;
    cmd.wr_en        = 1'b0;
    cmd.wr_shift     = 1'b0;
    cmd.idx_op       = IDX_HOLD;
    cmd.take_removed = 1'b0;
    cmd.fin          = FIN_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (stat.act)
          ACT_INSERT: begin
            if (stat.ins_bad) begin
              cmd.fin    = FIN_BAD_INDEX;
              state_next = S_IDLE;
            end else if (stat.full) begin
              cmd.fin    = FIN_FULL;
              state_next = S_IDLE;
            end else begin
              cmd.idx_op = IDX_COUNT;
              state_next = S_INS_TEST;
            end
          end
          ACT_DELETE: begin
            if (stat.del_bad) begin
              cmd.fin    = FIN_BAD_INDEX;
              state_next = S_IDLE;
            end else begin
              cmd.idx_op = IDX_POS;
              state_next = S_DEL_RD;
            end
          end
          ACT_SEARCH: begin
            cmd.idx_op = IDX_ZERO;
            state_next = S_SRCH_TEST;
          end
          default: begin
            cmd.fin    = FIN_MISS;
            state_next = S_IDLE;
          end
        endcase
      end
      // Walk down from the top, moving each entry up by one
      S_INS_TEST: begin
        if (stat.ins_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_INS_WR;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.fin    = FIN_INSERT;
          state_next = S_IDLE;
        end
      end
      S_INS_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.idx_op   = IDX_DEC;
        state_next   = S_INS_TEST;
      end
      S_DEL_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DEL_TAKE;
      end
      S_DEL_TAKE: begin
        cmd.take_removed = 1'b1;
        state_next       = S_DEL_TEST;
      end
      // Walk up from the hole, moving each entry down by one
      S_DEL_TEST: begin
        if (stat.del_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_DEL_WR;
        end else begin
          cmd.fin    = FIN_DELETE;
          state_next = S_IDLE;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.idx_op   = IDX_INC;
        state_next   = S_DEL_TEST;
      end
      S_SRCH_TEST: begin
        if (stat.srch_more) begin
          cmd.rd_en  = 1'b1;
          state_next = S_SRCH_CMP;
        end else begin
          cmd.fin    = FIN_MISS;
          state_next = S_IDLE;
        end
      end
      S_SRCH_CMP: begin
        if (stat.hit) begin
          cmd.fin    = FIN_HIT;
          state_next = S_IDLE;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_SRCH_TEST;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

[rtl/core/indexed_array_insert_delete_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed array insert / delete
// Packed ordered list of signed words with indexed insert, indexed delete and
// search; every result carries the entry count and the wrapping sum.
// ----------------------------------------------------------------------------
// Refused or unused items end at the check. An insert shifts the entries at
// position..count-1 up by one and writes the new word; a delete reads its
// entry and shifts those above it down by one; a search scans up from entry
// 0 to a match or the count. done is high for the one cycle in which busy
// drops, and a new item may start in that cycle. The receiver cannot stall.
// Reset clears the count, the sum and the strobe and sets the capacity to 10;
// the store itself is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module indexed_array_insert_delete_top #(
  parameter int MAX_ENTRIES = iad_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [iad_pkg::ACT_W-1:0]         action,
  input  wire logic [iad_pkg::POS_W-1:0]         position,
  input  wire logic signed [iad_pkg::DATA_W-1:0] item_value,
  output logic                                   done,
  output logic [iad_pkg::STAT_W-1:0]             status,
  output logic signed [iad_pkg::DATA_W-1:0]      removed_value,
  output logic                                   found,
  output logic signed [iad_pkg::DATA_W-1:0]      total,
  output logic [iad_pkg::COUNT_W-1:0]            count
);
  import iad_pkg::*;

  localparam logic REG_CAPACITY = 1'b0;

  logic [COUNT_W-1:0] capacity;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(32-COUNT_W){1'b0}}, capacity};
    end else begin
      prdata = '0;
    end
  end

  iad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  iad_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .capacity      (capacity),
    .action        (action_t'(action)),
    .position      (position),
    .item_value    (item_value),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .removed_value (removed_value),
    .found         (found),
    .total         (total),
    .count         (count)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_ENTRIES)
    else $error("entry count beyond store depth");

endmodule
`default_nettype wire

[tb/indexed_array_insert_delete_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed array insert / delete testbench
// Drives insert, delete, search and unused commands through the start/busy
// port and sets the capacity over the register port. A local copy of the
// packed list predicts every result, which is compared field by field.
// ----------------------------------------------------------------------------
module indexed_array_insert_delete_top_tb;
  import iad_pkg::*;

  localparam int          LIST_DEPTH = DEF_MAX_ENTRIES;
  localparam logic [2:0]  CAP_ADDR   = 3'd0;
  localparam int          DRAIN_WAIT = 80;
  localparam int          MAX_REPORTS = 10;

  typedef struct {
    status_t                   status;
    logic signed [DATA_W-1:0]  removed;
    logic                      found;
    logic signed [DATA_W-1:0]  total;
    logic [COUNT_W-1:0]        count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [ACT_W-1:0] action = '0;
  logic [POS_W-1:0] position = '0;
  logic signed [DATA_W-1:0] item_value = '0;
  logic done;
  logic [STAT_W-1:0] status;
  logic signed [DATA_W-1:0] removed_value;
  logic found;
  logic signed [DATA_W-1:0] total;
  logic [COUNT_W-1:0] count;

  // shadow copy of the list and the capacity register
  logic [DATA_W-1:0] list_words [LIST_DEPTH];
  int                list_len;
  logic [DATA_W-1:0] list_sum;
  logic [COUNT_W-1:0] cap_reg;

  list_result_t expected_results [$];
  list_result_t want;
  int mismatch_count = 0;
  int result_index = 0;

  int burst_left = 0;
  bit gaps_on = 1'b1;

  always #4 clk = ~clk;

  indexed_array_insert_delete_top DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .position      (position),
    .item_value    (item_value),
    .done          (done),
    .status        (status),
    .removed_value (removed_value),
    .found         (found),
    .total         (total),
    .count         (count)
  );

  function automatic list_result_t apply_list_op(input action_t act,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [DATA_W-1:0] val);
    list_result_t r;
    int i;
    int eff_cap;
    r.status  = ST_DONE;
    r.removed = '0;
    r.found   = 1'b0;
    eff_cap = (int'(cap_reg) < LIST_DEPTH) ? int'(cap_reg) : LIST_DEPTH;
    case (act)
      ACT_INSERT: begin
        if (int'(pos) > list_len) begin
          r.status  = ST_BAD_INDEX;
          r.removed = -1;
        end else if (list_len >= eff_cap) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > int'(pos); i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          list_len++;
          list_sum += val;
        end
      end
      ACT_DELETE: begin
        if (int'(pos) >= list_len) begin
          r.status  = ST_BAD_INDEX;
          r.removed = -1;
        end else begin
          r.removed = list_words[pos];
          for (i = int'(pos); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          list_sum -= r.removed;
        end
      end
      ACT_SEARCH: begin
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == val) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.total = list_sum;
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      result_index++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result %0d arrived with no item outstanding", result_index);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || removed_value !== want.removed ||
            found !== want.found || total !== want.total || count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"result %0d: status %0d/%0d removed %0d/%0d found %0d/%0d",
                      " total %0d/%0d count %0d/%0d (exp/got)"},
                     result_index, want.status, status, want.removed, removed_value,
                     want.found, found, want.total, total, want.count, count);
        end
      end
    end
  end

  task automatic send_item(input action_t act, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    int gap;
    start      <= 1'b1;
    action     <= act;
    position   <= pos;
    item_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(apply_list_op(act, pos, val));
    if (burst_left > 0) burst_left--;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [COUNT_W-1:0] cap);
    wait_drained();
    repeat (2) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {{(32-COUNT_W){1'b0}}, cap};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg = cap;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_item(ACT_DELETE, 5'd0, 32'sd0);
    send_item(ACT_SEARCH, 5'd0, 32'sd0);
    send_item(ACT_INSERT, 5'd1, 32'sd7);
  endtask

  task automatic test_edge_values();
    send_item(ACT_INSERT, 5'd0, 32'sh7fff_ffff);
    // sum reaches -1 here
    send_item(ACT_INSERT, 5'd0, 32'sh8000_0000);
    send_item(ACT_INSERT, 5'd2, -32'sd1);
    send_item(ACT_INSERT, 5'd1, 32'sd0);
    send_item(ACT_SEARCH, 5'd9, 32'sh8000_0000);
    send_item(ACT_SEARCH, 5'd0, -32'sd1);
    send_item(ACT_SEARCH, 5'd0, 32'sd5);
    send_item(ACT_NOP, 5'd31, -32'sd1);
    send_item(ACT_INSERT, 5'd31, 32'sd3);
    send_item(ACT_DELETE, 5'd31, 32'sd0);
    send_item(ACT_DELETE, 5'd4, 32'sd0);
  endtask

  task automatic test_capacity_limits();
    // capacity below the count: entries stay, inserts refused
    set_capacity(5'd1);
    send_item(ACT_INSERT, 5'd0, 32'sd11);
    send_item(ACT_INSERT, 5'd5, 32'sd11);
    set_capacity(5'd0);
    send_item(ACT_INSERT, 5'd0, 32'sd12);
    set_capacity(5'd31);
    send_item(ACT_INSERT, 5'd4, 32'sd1);
    send_item(ACT_DELETE, 5'd1, 32'sd0);
    send_item(ACT_DELETE, 5'd3, 32'sd0);
    send_item(ACT_DELETE, 5'd0, 32'sd0);
  endtask

  task automatic test_random_traffic();
    logic [COUNT_W-1:0] phase_cap [7];
    int phase_items [7];
    int p;
    int n;
    int roll;
    int ins_pct;
    action_t act;
    logic [POS_W-1:0] pos;
    logic signed [DATA_W-1:0] val;
    phase_cap   = '{5'd16, 5'd31, 5'd1, 5'd5, 5'd0, 5'd10, 5'd0};
    phase_items = '{300, 250, 150, 250, 80, 250, 250};
    phase_cap[6] = COUNT_W'($urandom_range(1, 16));
    for (p = 0; p < 7; p++) begin
      set_capacity(phase_cap[p]);
      gaps_on = (p % 3) != 1;
      burst_left = 0;
      ins_pct = (p == 0) ? 65 : $urandom_range(35, 65);
      for (n = 0; n < phase_items[p]; n++) begin
        roll = $urandom_range(0, 99);
        val = pick_value();
        if (roll < 8) begin
          // noise: any code, any index
          act = action_t'($urandom_range(0, 3));
          pos = POS_W'($urandom_range(0, 31));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < ins_pct) begin
            act = ACT_INSERT;
            pos = POS_W'($urandom_range(0, list_len));
          end else if (roll < ins_pct + (100 - ins_pct) / 2) begin
            act = ACT_DELETE;
            pos = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
          end else begin
            act = ACT_SEARCH;
            pos = POS_W'($urandom_range(0, 31));
            if (list_len > 0 && $urandom_range(0, 9) < 6)
              val = list_words[$urandom_range(0, list_len - 1)];
          end
        end
        send_item(act, pos, val);
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    list_len = 0;
    list_sum = '0;
    cap_reg  = CAP_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_edge_values();
    test_capacity_limits();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("indexed_array_insert_delete_top_tb: PASS");
    end else begin
      $display("indexed_array_insert_delete_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("indexed_array_insert_delete_top_tb: FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/iad_pkg.sv
rtl/core/iad_ram.sv
rtl/core/iad_dpath.sv
rtl/core/iad_ctrl.sv
rtl/core/indexed_array_insert_delete_top.sv
tb/indexed_array_insert_delete_top_tb.sv
